@@ rtl/core/imrlu_pkg.sv @@
package imrlu_pkg;

    // Memory geometry
    localparam int ROWS          = 128;
    localparam int WORDS_PER_ROW = 16;
    localparam int ROW_W         = $clog2(ROWS);
    localparam int WORD_W        = 4;
    localparam int ADDR_W        = ROW_W + WORD_W;
    localparam int MEM_DEPTH     = ROWS * WORDS_PER_ROW;

    // Row fields of the instruction are seven bits wide.
    localparam int ROW_FIELD_W    = 7;
    localparam int ROW_FIELD_SPAN = 1 << ROW_FIELD_W;

    // Bank boundaries: words 0-7, 8-9, 10-13 and 14-15.
    localparam logic [WORD_W-1:0] BANK1_BASE = 4'd8;
    localparam logic [WORD_W-1:0] BANK2_BASE = 4'd10;
    localparam logic [WORD_W-1:0] BANK3_BASE = 4'd14;
    localparam logic [WORD_W-1:0] LAST_WORD  = 4'(WORDS_PER_ROW - 1);

    typedef enum logic [1:0] {
        ACT_EXEC    = 2'd0,
        ACT_CAPTURE = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_AND  = 4'd1,
        OP_OR   = 4'd2,
        OP_XOR  = 4'd3,
        OP_COPY = 4'd4,
        OP_NOT  = 4'd5,
        OP_SHL1 = 4'd6,
        OP_SHL4 = 4'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] instr;
        logic        use_offset;
        logic [6:0]  row;
        logic [3:0]  word;
        logic [4:0]  shift;
        logic [31:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic [3:0]  nibble;
    } t_out_item;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_item;
        logic              rd_item;
        logic              rd_exec;
        logic              wr_host;
        logic              wr_exec;
        logic              out_load;
        logic [WORD_W-1:0] word;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    // Table that reduces a seven-bit row field modulo ROWS.
    typedef logic [ROW_FIELD_SPAN-1:0][ROW_W-1:0] t_row_tbl;

    function automatic t_row_tbl build_row_mod();
        t_row_tbl          tbl;
        logic [ROW_W-1:0]  v;
        v = '0;
        for (int i = 0; i < ROW_FIELD_SPAN; i++) begin
            tbl[i] = v;
            v = ((32'(v) + 1) == ROWS) ? '0 : v + ROW_W'(1);
        end
        return tbl;
    endfunction

    localparam t_row_tbl ROW_MOD = build_row_mod();

    // Bank number that covers a word position.
    function automatic logic [1:0] word_bank(input logic [WORD_W-1:0] w);
        logic [1:0] b;
        if (w < BANK1_BASE) begin
            b = 2'd0;
        end else if (w < BANK2_BASE) begin
            b = 2'd1;
        end else if (w < BANK3_BASE) begin
            b = 2'd2;
        end else begin
            b = 2'd3;
        end
        return b;
    endfunction

endpackage

@@ rtl/core/imrlu_ctrl.sv @@
module imrlu_ctrl
    import imrlu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_action_is_exec,
    input  logic     i_action_is_write,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // State and word counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    // Next state logic.
    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_word = '0;
                    if (i_action_is_exec) begin
                        n_state = ST_EXEC;
                    end else if (!i_action_is_write) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_EXEC: begin
                n_word = r_word + WORD_W'(1);
                if (r_word == LAST_WORD) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.word = r_word;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_item = accept;
                o_cmd.rd_item   = accept && !i_action_is_exec && !i_action_is_write;
                o_cmd.wr_host   = accept && i_action_is_write;
            end
            ST_EXEC: begin
                o_cmd.rd_exec = 1'b1;
                o_cmd.wr_exec = (r_word != '0);
            end
            ST_DRAIN: begin
                o_cmd.wr_exec = 1'b1;
            end
            ST_READ: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/core/imrlu_datapath.sv @@
module imrlu_datapath
    import imrlu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_ready,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic [31:0]       mem [MEM_DEPTH];

    logic [ROW_W-1:0]  r_ra;
    logic [ROW_W-1:0]  r_rb;
    logic [ROW_W-1:0]  r_rc;
    logic [3:0]        r_op;
    logic [3:0]        r_banks;
    logic [4:0]        r_shift;
    logic              r_capture;
    logic [3:0]        r_nibble;
    logic              r_carry1;
    logic [3:0]        r_carry4;
    logic [WORD_W-1:0] r_wword;
    logic [31:0]       r_rda;
    logic [31:0]       r_rdb;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [ROW_FIELD_W-1:0] row_a_field;
    logic [ADDR_W-1:0]      item_addr;
    logic [ADDR_W-1:0]      rd_addr_a;
    logic [ADDR_W-1:0]      rd_addr_b;
    logic [ADDR_W-1:0]      wr_addr;
    logic [31:0]            wr_data;
    logic                   wr_en;
    logic                   word_en;
    logic [31:0]            dc;
    logic [3:0]             new_nibble;

    // Row A with the optional captured offset, wrapping over the field range.
    always_comb begin
        row_a_field = i_item.instr[6:0];
        if (i_item.use_offset) begin
            row_a_field = i_item.instr[6:0] + ROW_FIELD_W'(r_nibble);
        end
    end

    assign item_addr = {ROW_MOD[i_item.row], i_item.word};

    // Read addresses: the item's word, or the current word of rows A and B.
    assign rd_addr_a = i_cmd.rd_exec ? {r_ra, i_cmd.word} : item_addr;
    assign rd_addr_b = {r_rb, i_cmd.word};

    // Word operation on the operands read in the previous cycle.
    assign word_en = r_banks[word_bank(r_wword)];

    always_comb begin
        case (r_op)
            OP_AND:  dc = r_rda & r_rdb;
            OP_OR:   dc = r_rda | r_rdb;
            OP_XOR:  dc = r_rda ^ r_rdb;
            OP_NOT:  dc = ~r_rda;
            OP_SHL1: dc = {r_rda[30:0], r_carry1};
            OP_SHL4: dc = {r_rda[27:0], r_carry4};
            default: dc = r_rda;
        endcase
    end

    // Write port: a host write or an execute result into row C.
    assign wr_en   = i_cmd.wr_host || (i_cmd.wr_exec && word_en);
    assign wr_addr = i_cmd.wr_host ? item_addr : {r_rc, r_wword};
    assign wr_data = i_cmd.wr_host ? i_item.wdata : dc;

    // Row memory with one write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_item || i_cmd.rd_exec) begin
            r_rda <= mem[rd_addr_a];
            r_rdb <= mem[rd_addr_b];
        end
    end

    // Item fields latched at each transfer, word tag and shift carries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_ra      <= ROW_MOD[row_a_field];
            r_rb      <= ROW_MOD[i_item.instr[14:8]];
            r_rc      <= ROW_MOD[i_item.instr[22:16]];
            r_op      <= i_item.instr[27:24];
            r_banks   <= i_item.instr[31:28];
            r_shift   <= i_item.shift;
            r_capture <= (i_item.action == ACT_CAPTURE);
            r_carry1  <= 1'b0;
            r_carry4  <= '0;
        end else if (i_cmd.wr_exec && word_en) begin
            r_carry1 <= r_rda[31];
            r_carry4 <= r_rda[31:28];
        end
        if (i_cmd.rd_exec) begin
            r_wword <= i_cmd.word;
        end
    end

    // Nibble picked out of the word just read.
    assign new_nibble = 4'((r_rda >> r_shift) & 32'hF);

    // Captured nibble and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                if (r_capture) begin
                    r_nibble <= new_nibble;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.rdata  <= r_rda;
            r_out.nibble <= r_capture ? new_nibble : r_nibble;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out;

endmodule

@@ rtl/core/in_memory_row_logic_unit.sv @@
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// An execute steps through the transfer, one read per word position over all
// sixteen words, and a final write of the last word. A host write ends in its transfer;
// a capture or host read goes through the read register into the result register.
// The next transfer is taken when the controller is back in idle.
// Reset clears the controller, the result valid flag and the captured nibble only.
// A stalled result holds; a capture or read waits only if the result register is full.
module in_memory_row_logic_unit
    import imrlu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer for the item actions.
    imrlu_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_action_is_exec  (i_in_item.action == ACT_EXEC),
        .i_action_is_write (i_in_item.action == ACT_WRITE),
        .i_stat            (stat),
        .o_in_ready        (o_in_ready),
        .o_cmd             (cmd)
    );

    // Row memory, word unit and result register.
    imrlu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

@@ rtl/core/imrlu_checker.sv @@
module imrlu_checker
    import imrlu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic in_xfer;
    logic read_xfer;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign read_xfer = in_xfer && ((i_in_item.action == ACT_CAPTURE) ||
                                   (i_in_item.action == ACT_READ));

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // A new result appears only after a capture or read transfer, through the read and result registers.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(read_xfer, 2))
        else $error("result without a capture or read transfer");

    // An execute keeps the input closed until its last word is written.
    a_exec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_item.action == ACT_EXEC) |=> !o_in_ready)
        else $error("input reopened during execute");

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_item.action == ACT_EXEC) |-> ##18 o_in_ready)
        else $error("execute did not finish in 18 cycles");

    // A host write completes in the cycle of its transfer.
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_in_item.action == ACT_WRITE) |=> o_in_ready)
        else $error("host write did not complete");

endmodule

bind in_memory_row_logic_unit imrlu_checker u_checker (.*);
